[hw/rtl/pidc_pkg.sv]
package pidc_pkg;

  localparam int FRAC_BITS    = 12;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ERR_W        = SAMPLE_WIDTH + 1;
  localparam int GAIN_W       = 24;
  localparam int LIM_W        = 31;
  localparam int ACC_W        = 48;
  localparam int DRIVE_W      = 32;
  localparam int OP_W         = ERR_W + 2;
  localparam int PROD_W       = OP_W + GAIN_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM = 3'd5;

  // form codes
  localparam logic FORM_INCR = 1'b0;
  localparam logic FORM_POS  = 1'b1;

  localparam logic [LIM_W-1:0] OUT_LIM_RST = LIM_W'(10000);

  // largest accumulator magnitude any clamp can allow
  localparam logic signed [ACC_W-1:0] ACC_MAX =
    {{(ACC_W-LIM_W-FRAC_BITS){1'b0}}, {LIM_W{1'b1}}, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic              form_sel;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]  int_lim;
    logic [LIM_W-1:0]  out_lim;
  } pidc_cfg_t;

  typedef struct packed {
    logic [ERR_W-1:0] err_now;
    logic [ERR_W-1:0] err_prev;
    logic [ERR_W-1:0] err_prev2;
    logic [ACC_W-1:0] integ;
    logic [ACC_W-1:0] out_acc;
  } pidc_state_t;

  function automatic logic signed [ACC_W-1:0] clamp_mag(
    input logic signed [ACC_W-1:0] x,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [ACC_W-1:0] bound;
    bound = {{(ACC_W-LIM_W-FRAC_BITS){1'b0}}, lim, {FRAC_BITS{1'b0}}};
    if (x > bound) begin
      return bound;
    end else if (x < -bound) begin
      return -bound;
    end
    return x;
  endfunction

endpackage

[hw/rtl/pid_controller_step_top.sv]
// Fixed-point PID controller: each input transfer carries a setpoint and a
// measured sample and yields exactly one output transfer with the clamped
// drive value (output accumulator >>> 12). Gains are signed Q12.12; form
// register 0 picks incremental (velocity) form, 1 picks positional form, and
// a zero integral or derivative gain drops that term. The block takes one
// sample per clock while out_ready keeps the result register free; a sample
// moves through the input register, then the result register. The rate is
// set by the loop from the error history and accumulators through the three
// gain multipliers, add and clamp back into the state registers. One sample
// can wait in the input register while a result waits on out_ready.
// Configuration writes are always accepted (cfg_ready is tied high); indexes
// beyond 5 are dropped, and writes belong in idle periods only.
module pid_controller_step_top (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // sample channel
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] in_setpoint,
  input  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] in_measured,
  // result channel
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [pidc_pkg::DRIVE_W-1:0]      out_drive,
  // configuration write channel
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import pidc_pkg::*;

  pidc_cfg_t   cfg_r;
  pidc_state_t state_r, state_nxt;

  logic                           in_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] sp_r, mv_r;
  logic                           out_vld_r;
  logic signed [DRIVE_W-1:0]      drive_r, drive_nxt;
  logic                           adv;

  // -------- configuration registers --------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.form_sel <= FORM_INCR;
      cfg_r.gain_p   <= '0;
      cfg_r.gain_i   <= '0;
      cfg_r.gain_d   <= '0;
      cfg_r.int_lim  <= '0;
      cfg_r.out_lim  <= OUT_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORM:    cfg_r.form_sel <= cfg_data[0];
        REG_GAIN_P:  cfg_r.gain_p   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:  cfg_r.gain_i   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:  cfg_r.gain_d   <= cfg_data[GAIN_W-1:0];
        REG_INT_LIM: cfg_r.int_lim  <= cfg_data[LIM_W-1:0];
        REG_OUT_LIM: cfg_r.out_lim  <= cfg_data[LIM_W-1:0];
        default:     ; // unmapped index: write dropped
      endcase
    end
  end

  // -------- pipeline control --------
  // advance the input register into the result register when it has room
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // input register: payload only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sp_r <= in_setpoint;
      mv_r <= in_measured;
    end
  end

  // -------- datapath --------
  pidc_calc u_calc (
    .cfg       (cfg_r),
    .state_cur (state_r),
    .setpoint  (sp_r),
    .measured  (mv_r),
    .state_nxt (state_nxt),
    .drive     (drive_nxt)
  );

  // controller state updates once per sample, as it moves to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_drive = drive_r;

  // -------- assertions --------
  a_out_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ($signed(state_r.out_acc) <= ACC_MAX) && ($signed(state_r.out_acc) >= -ACC_MAX))
    else $error("output accumulator beyond clamp range");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ($signed(state_r.integ) <= ACC_MAX) && ($signed(state_r.integ) >= -ACC_MAX))
    else $error("integral accumulator beyond clamp range");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("controller state changed without a sample");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced sample produced no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("empty input register not ready");

endmodule

[hw/rtl/pidc_calc.sv]
module pidc_calc (
  input  pidc_pkg::pidc_cfg_t                           cfg,
  input  pidc_pkg::pidc_state_t                         state_cur,
  input  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0]      setpoint,
  input  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0]      measured,
  output pidc_pkg::pidc_state_t                         state_nxt,
  output logic signed [pidc_pkg::DRIVE_W-1:0]           drive
);
  import pidc_pkg::*;

  logic signed [ERR_W-1:0]  err, e1, e2;
  logic signed [OP_W-1:0]   d1, d2, op_p, op_d, op_i;
  logic signed [GAIN_W-1:0] gp, gi, gd;
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
  logic signed [ACC_W-1:0]  sum_pd, integ_sum, out_old, integ_old;
  logic                     incr, gi_on;

  assign incr  = (cfg.form_sel == FORM_INCR);
  assign gi_on = (cfg.gain_i != '0);

  assign gp        = $signed(cfg.gain_p);
  assign gi        = $signed(cfg.gain_i);
  assign gd        = $signed(cfg.gain_d);
  assign e1        = $signed(state_cur.err_now);
  assign e2        = $signed(state_cur.err_prev);
  assign out_old   = $signed(state_cur.out_acc);
  assign integ_old = $signed(state_cur.integ);

  assign err = ERR_W'(setpoint) - ERR_W'(measured);
  assign d1  = OP_W'(err) - OP_W'(e1);
  assign d2  = OP_W'(err) - (OP_W'(e1) <<< 1) + OP_W'(e2);

  // three multipliers shared by both forms; P and D operands picked by form
  assign op_p = incr ? d1 : OP_W'(err);
  assign op_d = incr ? d2 : d1;
  assign op_i = OP_W'(err);

  assign prod_p = PROD_W'(op_p) * PROD_W'(gp);
  assign prod_i = PROD_W'(op_i) * PROD_W'(gi);
  assign prod_d = PROD_W'(op_d) * PROD_W'(gd);

  assign sum_pd    = ACC_W'(prod_p) + ACC_W'(prod_d);
  assign integ_sum = clamp_mag(integ_old + ACC_W'(prod_i), cfg.int_lim);

  always_comb begin
    state_nxt = state_cur;
    if (incr) begin
      state_nxt.err_prev2 = state_cur.err_prev;
      state_nxt.err_prev  = state_cur.err_now;
      state_nxt.err_now   = err;
      state_nxt.out_acc   = clamp_mag(out_old + sum_pd + ACC_W'(prod_i), cfg.out_lim);
    end else begin
      state_nxt.err_prev = state_cur.err_now;
      state_nxt.err_now  = err;
      if (gi_on) begin
        state_nxt.integ   = integ_sum;
        state_nxt.out_acc = clamp_mag(sum_pd + integ_sum, cfg.out_lim);
      end else begin
        state_nxt.out_acc = clamp_mag(sum_pd, cfg.out_lim);
      end
    end
  end

  // arithmetic shift right; clamp keeps the result within 32 bits
  assign drive = $signed(state_nxt.out_acc[FRAC_BITS+DRIVE_W-1:FRAC_BITS]);

endmodule
